// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ACBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("acbc assertion failed");

// Condition that must never be seen outside reset.
`define ACBC_NEVER(label, expr) \
  `ACBC_ASSERT(label, !(expr))

`endif

// ----- src/acbc_pkg.sv -----
// Package for the allele count base caller: widths, register codes,
// base letters and the ambiguity table. No dependencies.
package acbc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int FRAC_W = FRAC_BITS + 1;
  localparam int PROD_W = COUNT_BITS + FRAC_BITS + 1;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [COUNT_BITS-1:0] MIN_DEPTH_RESET = COUNT_BITS'(1);
  localparam logic [FRAC_W-1:0] HET_RESET = FRAC_W'((1 << FRAC_BITS) / 5);

  typedef enum logic [1:0] {
    REG_CALL_MODE    = 2'd0,
    REG_MIN_DEPTH    = 2'd1,
    REG_HET_FRACTION = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_HAPLOID = 2'd0,
    MODE_IUPAC   = 2'd1,
    MODE_SPLIT   = 2'd2
  } call_mode_t;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_K = 8'h4B;

  typedef struct packed {
    logic [1:0] major;
    logic [1:0] minor;
    logic       has_major;
    logic       has_minor;
  } rank_t;

  function automatic logic [7:0] letter_of(input logic [1:0] b);
    logic [7:0] ch;
    case (b)
      2'd0:    ch = CH_A;
      2'd1:    ch = CH_C;
      2'd2:    ch = CH_G;
      2'd3:    ch = CH_T;
      default: ch = CH_N;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ambig_of(input logic [1:0] a, input logic [1:0] b);
    logic [7:0] ch;
    case ({a, b})
      4'b0000:          ch = CH_A;
      4'b0101:          ch = CH_C;
      4'b1010:          ch = CH_G;
      4'b1111:          ch = CH_T;
      4'b0001, 4'b0100: ch = CH_M;
      4'b0010, 4'b1000: ch = CH_R;
      4'b0011, 4'b1100: ch = CH_W;
      4'b0110, 4'b1001: ch = CH_S;
      4'b0111, 4'b1101: ch = CH_Y;
      4'b1011, 4'b1110: ch = CH_K;
      default:          ch = CH_N;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/allele_count_base_caller_top.sv -----
// Top level of the allele count base caller: APB registers and the
// three-stage call pipeline. Depends on acbc_pkg, acbc_rank, assert_macros.svh.
//
// One site per beat, one call per site; start is registered through s1_valid and s2_valid to done.
// A beat is taken in every cycle (busy stays low); the result is on
// base_first/base_second for the single cycle that done is high, with no
// way to hold it. Stage one compares the counts pairwise and against
// min_depth, stage two ranks the alleles and forms het_fraction*site_depth,
// stage three makes the fraction test and the letters.
`include "assert_macros.svh"

module allele_count_base_caller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [acbc_pkg::ADDR_W-1:0]      paddr,
  input  logic [acbc_pkg::DATA_W-1:0]      pwdata,
  output logic [acbc_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic [acbc_pkg::COUNT_BITS-1:0]  count_a,
  input  logic [acbc_pkg::COUNT_BITS-1:0]  count_c,
  input  logic [acbc_pkg::COUNT_BITS-1:0]  count_g,
  input  logic [acbc_pkg::COUNT_BITS-1:0]  count_t,
  input  logic [acbc_pkg::COUNT_BITS-1:0]  site_depth,
  output logic                             done,
  output logic [7:0]                       base_first,
  output logic [7:0]                       base_second
);
  import acbc_pkg::*;

  logic [MODE_W-1:0]     call_mode;
  logic [COUNT_BITS-1:0] min_depth;
  logic [FRAC_W-1:0]     het_fraction;

  logic                  wr_en;
  cfg_reg_t              reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      call_mode    <= MODE_IUPAC;
      min_depth    <= MIN_DEPTH_RESET;
      het_fraction <= HET_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CALL_MODE:    call_mode    <= pwdata[MODE_W-1:0];
        REG_MIN_DEPTH:    min_depth    <= pwdata[COUNT_BITS-1:0];
        REG_HET_FRACTION: het_fraction <= pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CALL_MODE:    prdata = DATA_W'(call_mode);
      REG_MIN_DEPTH:    prdata = DATA_W'(min_depth);
      REG_HET_FRACTION: prdata = DATA_W'(het_fraction);
      default:          prdata = '0;
    endcase
  end

  // stage 1: pairwise compares
  logic [3:0][COUNT_BITS-1:0] cnt_in;
  logic [3:0][3:0]            gt_next;
  logic [3:0]                 nz_next;

  assign cnt_in = {count_t, count_g, count_c, count_a};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz_next[i] = cnt_in[i] != '0;
      for (int j = 0; j < 4; j++) begin
        gt_next[i][j] = cnt_in[i] > cnt_in[j];
      end
    end
  end

  logic                       s1_valid;
  logic [3:0][COUNT_BITS-1:0] s1_cnt;
  logic [3:0][3:0]            s1_gt;
  logic [3:0]                 s1_nz;
  logic [COUNT_BITS-1:0]      s1_depth;
  logic                       s1_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_cnt   <= cnt_in;
    s1_gt    <= gt_next;
    s1_nz    <= nz_next;
    s1_depth <= site_depth;
    s1_low   <= site_depth < min_depth;
  end

  // stage 2: ranking and threshold product
  rank_t rank;

  acbc_rank u_rank (
    .nz   (s1_nz),
    .gt   (s1_gt),
    .rank (rank)
  );

  logic                  s2_valid;
  logic [1:0]            s2_major;
  logic [1:0]            s2_minor;
  logic                  s2_has_minor;
  logic                  s2_no_call;
  logic [COUNT_BITS-1:0] s2_minor_cnt;
  logic [PROD_W-1:0]     s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_major     <= rank.major;
    s2_minor     <= rank.minor;
    s2_has_minor <= rank.has_minor;
    s2_no_call   <= s1_low || !rank.has_major;
    s2_minor_cnt <= s1_cnt[rank.minor];
    s2_prod      <= PROD_W'(het_fraction) * PROD_W'(s1_depth);
  end

  // stage 3: fraction test and letters
  logic [PROD_W-1:0] lhs;
  logic              het;
  logic [7:0]        first_next;
  logic [7:0]        second_next;

  assign lhs = PROD_W'({s2_minor_cnt, {FRAC_BITS{1'b0}}});
  assign het = s2_has_minor && (lhs >= s2_prod);

  always_comb begin
    first_next  = letter_of(s2_major);
    second_next = first_next;
    if (s2_no_call) begin
      first_next  = CH_N;
      second_next = CH_N;
    end else if (het) begin
      if (call_mode == MODE_IUPAC) begin
        first_next  = ambig_of(s2_major, s2_minor);
        second_next = first_next;
      end else if (call_mode == MODE_SPLIT) begin
        second_next = letter_of(s2_minor);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    base_first  <= first_next;
    base_second <= second_next;
  end

  `ACBC_ASSERT(a_done_follows_start, done |-> $past(start && !busy, 3))
  `ACBC_ASSERT(a_start_gives_done, (start && !busy) |=> ##2 done)
  `ACBC_NEVER(a_n_pairs, done && base_first == CH_N && base_second != CH_N)
  `ACBC_NEVER(a_haploid_same, done && call_mode == MODE_HAPLOID && base_first != base_second)

endmodule

// ----- src/acbc_rank.sv -----
// Ranks the two most frequent non-zero alleles from pairwise compare bits.
// Depends on acbc_pkg.
module acbc_rank (
  input  logic [3:0]       nz,
  input  logic [3:0][3:0]  gt,
  output acbc_pkg::rank_t  rank
);
  import acbc_pkg::*;

  always_comb begin
    logic [1:0] maj;
    logic [1:0] mnr;
    logic       maj_ok;
    logic       mnr_ok;
    maj    = 2'd0;
    mnr    = 2'd0;
    maj_ok = 1'b0;
    mnr_ok = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (nz[k]) begin
        if (!maj_ok || gt[k][maj]) begin
          mnr    = maj;
          mnr_ok = maj_ok;
          maj    = 2'(k);
          maj_ok = 1'b1;
        end else if (!mnr_ok || gt[k][mnr]) begin
          mnr    = 2'(k);
          mnr_ok = 1'b1;
        end
      end
    end
    rank.major     = maj;
    rank.minor     = mnr;
    rank.has_major = maj_ok;
    rank.has_minor = mnr_ok;
  end

endmodule

// ----- dv/tb_allele_count_base_caller_top.sv -----
// Self-checking testbench for allele_count_base_caller_top: directed and random
// sites through the start/done port, registers set over APB, calls predicted here.
// Depends on acbc_pkg and the RTL under src/.
module tb_allele_count_base_caller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acbc_pkg::*;

  localparam int CALL_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } site_call_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COUNT_BITS-1:0] count_a = '0;
  logic [COUNT_BITS-1:0] count_c = '0;
  logic [COUNT_BITS-1:0] count_g = '0;
  logic [COUNT_BITS-1:0] count_t = '0;
  logic [COUNT_BITS-1:0] site_depth = '0;
  logic                  done;
  logic [7:0]            base_first;
  logic [7:0]            base_second;

  allele_count_base_caller_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .count_a(count_a), .count_c(count_c), .count_g(count_g), .count_t(count_t),
    .site_depth(site_depth),
    .done(done), .base_first(base_first), .base_second(base_second)
  );

  always #6 clk = ~clk;

  // Local copy of the registers
  logic [1:0]            cfg_mode = MODE_IUPAC;
  logic [COUNT_BITS-1:0] cfg_min_depth = 16'd1;
  logic [FRAC_W-1:0]     cfg_het = 17'd13107;

  site_call_t calls_pending[$];
  int         err_count = 0;
  int         idle_max = 14;

  localparam logic [7:0] BASE_LETTER [4] = '{CH_A, CH_C, CH_G, CH_T};
  localparam logic [7:0] IUPAC_CODE [4][4] = '{
    '{CH_A, CH_M, CH_R, CH_W},
    '{CH_M, CH_C, CH_S, CH_Y},
    '{CH_R, CH_S, CH_G, CH_K},
    '{CH_W, CH_Y, CH_K, CH_T}
  };

  function automatic site_call_t predict_call(input logic [3:0][COUNT_BITS-1:0] cnt,
                                              input logic [COUNT_BITS-1:0] depth);
    int              major;
    int              minor;
    bit              het;
    longint unsigned frac_lhs;
    longint unsigned frac_rhs;
    site_call_t      c;
    major = -1;
    minor = -1;
    het = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (cnt[k] != '0) begin
        if (major < 0 || cnt[k] > cnt[major]) begin
          minor = major;
          major = k;
        end else if (minor < 0 || cnt[k] > cnt[minor]) begin
          minor = k;
        end
      end
    end
    if (depth < cfg_min_depth || major < 0) begin
      c.first = CH_N;
      c.second = CH_N;
      return c;
    end
    if (minor >= 0) begin
      frac_lhs = longint'(cnt[minor]) << FRAC_BITS;
      frac_rhs = longint'(cfg_het) * longint'(depth);
      het = frac_lhs >= frac_rhs;
    end
    c.first = BASE_LETTER[major];
    c.second = c.first;
    if (het) begin
      case (cfg_mode)
        MODE_IUPAC: begin
          c.first = IUPAC_CODE[major][minor];
          c.second = c.first;
        end
        MODE_SPLIT: c.second = BASE_LETTER[minor];
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Results
  always @(posedge clk) begin : check_calls
    site_call_t want;
    if (!rst && done) begin
      if (calls_pending.size() == 0) begin
        report_mismatch($sformatf("call %h/%h with none expected", base_first, base_second));
      end else begin
        want = calls_pending.pop_front();
        if (base_first !== want.first)
          report_mismatch($sformatf("base_first %h, expected %h", base_first, want.first));
        if (base_second !== want.second)
          report_mismatch($sformatf("base_second %h, expected %h", base_second, want.second));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (psel && penable && pready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_allele_count_base_caller_top: errors");
    $finish;
  end

  task automatic check_reg(input cfg_reg_t r);
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] got;
    case (r)
      REG_CALL_MODE:    want = DATA_W'(cfg_mode);
      REG_MIN_DEPTH:    want = DATA_W'(cfg_min_depth);
      REG_HET_FRACTION: want = DATA_W'(cfg_het);
      default:          want = '0;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch($sformatf("register %s reads %h, expected %h",
                                                r.name(), got, want));
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (r)
      REG_CALL_MODE:    cfg_mode = value[1:0];
      REG_MIN_DEPTH:    cfg_min_depth = value[COUNT_BITS-1:0];
      REG_HET_FRACTION: cfg_het = value[FRAC_W-1:0];
      default: ;
    endcase
    check_reg(r);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [COUNT_BITS-1:0] min_d,
                            input logic [FRAC_W-1:0] het);
    write_reg(REG_CALL_MODE, DATA_W'(mode));
    write_reg(REG_MIN_DEPTH, DATA_W'(min_d));
    write_reg(REG_HET_FRACTION, DATA_W'(het));
  endtask

  // One site per beat; start is left high so a following beat can go back to back
  task automatic send_site(input logic [COUNT_BITS-1:0] a, input logic [COUNT_BITS-1:0] c,
                           input logic [COUNT_BITS-1:0] g, input logic [COUNT_BITS-1:0] t,
                           input logic [COUNT_BITS-1:0] depth);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    count_a <= a;
    count_c <= c;
    count_g <= g;
    count_t <= t;
    site_depth <= depth;
    do @(posedge clk); while (busy);
    calls_pending.push_back(predict_call({t, g, c, a}, depth));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (calls_pending.size() != 0) @(posedge clk);
    repeat (CALL_LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_reset_config();
    check_reg(REG_CALL_MODE);
    check_reg(REG_MIN_DEPTH);
    check_reg(REG_HET_FRACTION);
    send_site(0, 0, 0, 0, 0);
    send_site(0, 0, 0, 0, 100);
    send_site(5, 0, 0, 0, 0);
    send_site(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_site(0, 30, 10, 0, 40);
    send_site(0, 65534, 1, 0, 65535);
    wait_drained();
  endtask

  task automatic test_iupac_pairs();
    set_config(MODE_IUPAC, 16'd1, '0);
    send_site(9, 3, 0, 0, 12);
    send_site(3, 0, 9, 0, 12);
    send_site(7, 0, 0, 2, 9);
    send_site(0, 2, 7, 0, 9);
    send_site(0, 6, 0, 6, 12);
    send_site(0, 0, 1, 8, 9);
    send_site(4, 4, 4, 0, 12);
    wait_drained();
  endtask

  task automatic test_output_modes();
    set_config(MODE_SPLIT, 16'd1, 17'd13107);
    send_site(0, 3, 0, 9, 12);
    send_site(10, 0, 1, 0, 11);
    wait_drained();
    write_reg(REG_CALL_MODE, DATA_W'(MODE_HAPLOID));
    send_site(0, 3, 0, 9, 12);
    wait_drained();
    // unused mode code falls back to haploid
    write_reg(REG_CALL_MODE, DATA_W'(2'd3));
    send_site(0, 3, 0, 9, 12);
    wait_drained();
  endtask

  task automatic test_depth_and_fraction();
    set_config(MODE_IUPAC, 16'd0, 17'h1FFFF);
    send_site(0, 5, 2, 0, 0);
    send_site(0, 5, 2, 0, 1);
    send_site(0, 5, 2, 0, 2);
    wait_drained();
    write_reg(REG_HET_FRACTION, DATA_W'(17'd65536));
    send_site(10, 10, 0, 0, 10);
    wait_drained();
    write_reg(REG_HET_FRACTION, DATA_W'(17'd32768));
    send_site(0, 100, 50, 0, 100);
    send_site(0, 100, 49, 0, 100);
    wait_drained();
    write_reg(REG_MIN_DEPTH, DATA_W'(16'hFFFF));
    send_site(0, 0, 0, 1, 16'hFFFF);
    send_site(0, 0, 0, 1, 16'hFFFE);
    wait_drained();
  endtask

  function automatic logic [COUNT_BITS-1:0] draw_count();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return COUNT_BITS'($urandom_range(1, 4));
      3:       return COUNT_BITS'($urandom_range(0, 65535));
      4:       return '1;
      default: return COUNT_BITS'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic test_random_sites();
    logic [COUNT_BITS-1:0] a, c, g, t, depth;
    logic [1:0]            mode;
    logic [COUNT_BITS-1:0] min_d;
    logic [FRAC_W-1:0]     het;
    int                    total;
    for (int phase = 0; phase < 6; phase++) begin
      mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0:       min_d = '0;
        1:       min_d = COUNT_BITS'($urandom_range(1, 8));
        2:       min_d = COUNT_BITS'($urandom_range(0, 65535));
        default: min_d = COUNT_BITS'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 5))
        0:       het = '0;
        1:       het = 17'd65536;
        2:       het = FRAC_W'($urandom_range(65537, 131071));
        3:       het = FRAC_W'($urandom_range(0, 65536));
        default: het = FRAC_W'($urandom_range(3000, 35000));
      endcase
      set_config(mode, min_d, het);
      idle_max = phase[0] ? 0 : 14;
      for (int i = 0; i < 84; i++) begin
        a = draw_count();
        c = draw_count();
        g = draw_count();
        t = draw_count();
        case ($urandom_range(0, 5))
          0: c = a;
          1: t = g;
          default: ;
        endcase
        total = int'(a) + int'(c) + int'(g) + int'(t);
        case ($urandom_range(0, 9))
          0:       depth = COUNT_BITS'($urandom_range(0, 65535));
          1:       depth = '0;
          2:       depth = COUNT_BITS'($urandom_range(0, total > 65535 ? 65535 : total));
          default: depth = (total > 65535) ? '1 : COUNT_BITS'(total);
        endcase
        send_site(a, c, g, t, depth);
      end
      wait_drained();
    end
    idle_max = 14;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_iupac_pairs();
    test_output_modes();
    test_depth_and_fraction();
    test_random_sites();
    wait_drained();
    if (err_count == 0) begin
      $display("tb_allele_count_base_caller_top: clean");
    end else begin
      $display("tb_allele_count_base_caller_top: errors");
    end
    $finish;
  end

endmodule
